// ===== sv/mtmfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtmfd_pkg
// Shared widths, constants and register codes for the multi-turn motor
// feedback decoder.
// ----------------------------------------------------------------------------
package mtmfd_pkg;

   // Field widths
   localparam int POS_W      = 16;
   localparam int SPEED_W    = 16;
   localparam int CURRENT_W  = 16;
   localparam int TEMP_W     = 8;
   localparam int MULTI_W    = 40;
   localparam int DELTA_W    = 17;
   localparam int TURN_OUT_W = 24;
   localparam int ANGLE_W    = 49;
   localparam int SPD_OUT_W  = 19;
   localparam int TORQUE_W   = 40;
   localparam int TORQUE_K_W = 24;
   localparam int BIAS_W     = 18;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // Parameter defaults
   localparam int TURN_BITS_DEF  = 24;
   localparam int CAL_FRAMES_DEF = 10;

   // Calibration constants
   localparam int LOAD_FRAMES = 2;
   localparam int BIAS_WINDOW = 32700;

   // Register reset values
   localparam logic [POS_W-1:0]      ZERO_OFFSET_RESET = '0;
   localparam logic [TORQUE_K_W-1:0] TORQUE_K_RESET    = 24'd291397;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ZERO_OFFSET = 2'd0,
      CSR_TORQUE_K    = 2'd1,
      CSR_SPEED_MODE  = 2'd2
   } csr_index_type;

endpackage

// ===== sv/mtmfd_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtmfd channel interfaces
// Feedback frame, decoded result and register write channels.
// ----------------------------------------------------------------------------
interface mtmfd_req_if
   import mtmfd_pkg::*;
();
   logic                        valid;
   logic                        ready;
   logic        [POS_W-1:0]     position_raw;
   logic signed [SPEED_W-1:0]   speed_raw;
   logic signed [CURRENT_W-1:0] current_raw;
   logic        [TEMP_W-1:0]    temp_raw;

   modport source (output valid, position_raw, speed_raw, current_raw, temp_raw,
                   input ready);
   modport sink   (input valid, position_raw, speed_raw, current_raw, temp_raw,
                   output ready);
endinterface

interface mtmfd_rsp_if
   import mtmfd_pkg::*;
();
   logic                         valid;
   logic                         ready;
   logic signed [MULTI_W-1:0]    multi_turn_position;
   logic signed [DELTA_W-1:0]    step_delta;
   logic signed [TURN_OUT_W-1:0] turn_count;
   logic signed [ANGLE_W-1:0]    angle_deg_q16;
   logic signed [SPD_OUT_W-1:0]  speed_sixth_dps;
   logic signed [TORQUE_W-1:0]   torque_q24;
   logic        [TEMP_W-1:0]     temperature;

   modport source (output valid, multi_turn_position, step_delta, turn_count,
                   angle_deg_q16, speed_sixth_dps, torque_q24, temperature,
                   input ready);
   modport sink   (input valid, multi_turn_position, step_delta, turn_count,
                   angle_deg_q16, speed_sixth_dps, torque_q24, temperature,
                   output ready);
endinterface

interface mtmfd_csr_if
   import mtmfd_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/multi_turn_motor_feedback_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_turn_motor_feedback_decoder_core
// Unwraps a single-turn encoder count into a multi-turn position and angle,
// tracks a start-up zero bias, and scales speed and current.
// ----------------------------------------------------------------------------
//  channel   direction  handshake     payload
//  req_ch    in         valid/ready   position, speed, current, temperature
//  rsp_ch    out        valid/ready   position, delta, turns, angle, speed,
//                                     torque, temperature
//  csr_ch    in         valid/ready   register index, write data
//
//  One frame per cycle while the result channel is not stalled; a frame passes
//  the input register, then the result register, before rsp valid rises.
//  The turn and bias update is a single pass between those two registers,
//  so back-to-back frames need no stall.
//  Synchronous active-high reset clears the valids and the tracking state.
//  A full result register holds while the input register can still take one
//  more frame; csr writes are taken in every cycle.
// ----------------------------------------------------------------------------
module multi_turn_motor_feedback_decoder_core
   import mtmfd_pkg::*;
#(
   parameter int TURN_BITS  = TURN_BITS_DEF,
   parameter int CAL_FRAMES = CAL_FRAMES_DEF
) (
   input  logic     clock,
   input  logic     reset,
   mtmfd_req_if.sink   req_ch,
   mtmfd_rsp_if.source rsp_ch,
   mtmfd_csr_if.sink   csr_ch
);

   localparam int MW   = TURN_BITS + POS_W;
   localparam int FC_W = $clog2(CAL_FRAMES + 2);
   localparam logic signed [ANGLE_W-1:0] WIN_POS = ANGLE_W'(BIAS_WINDOW);
   localparam logic signed [ANGLE_W-1:0] WIN_NEG = -WIN_POS;
   localparam logic signed [DELTA_W-1:0] HALF_POS = DELTA_W'(32768);
   localparam logic signed [DELTA_W-1:0] HALF_NEG = -HALF_POS;
   localparam logic signed [DELTA_W-1:0] FULL_TURN = DELTA_W'(65536);

   // Configuration registers
   logic [POS_W-1:0]      zero_offset_ff;
   logic [TORQUE_K_W-1:0] torque_k_ff;
   logic                  speed_mode_ff;

   // Input register
   logic                        a_valid_ff;
   logic        [POS_W-1:0]     a_pos_ff;
   logic signed [SPEED_W-1:0]   a_speed_ff;
   logic signed [CURRENT_W-1:0] a_current_ff;
   logic        [TEMP_W-1:0]    a_temp_ff;

   // Tracking state
   logic        [POS_W-1:0]     prev_pos_ff,    prev_pos_in;
   logic        [TURN_BITS-1:0] turns_ff,       turns_in;
   logic signed [BIAS_W-1:0]    zero_bias_ff,   zero_bias_in;
   logic        [FC_W-1:0]      frame_count_ff, frame_count_in;

   // Result register
   logic                         rsp_valid_ff;
   logic signed [MULTI_W-1:0]    multi_ff,  multi_in;
   logic signed [DELTA_W-1:0]    delta_ff,  delta_in;
   logic signed [TURN_OUT_W-1:0] turn_ff,   turn_in;
   logic signed [ANGLE_W-1:0]    angle_ff,  angle_in;
   logic signed [SPD_OUT_W-1:0]  speed_ff,  speed_in;
   logic signed [TORQUE_W-1:0]   torque_ff, torque_in;
   logic        [TEMP_W-1:0]     temp_ff;

   // Datapath intermediates
   logic                        a_load;
   logic                        b_load;
   logic signed [DELTA_W-1:0]   diff;
   logic signed [BIAS_W-1:0]    bias_cur;
   logic signed [MW-1:0]        multi_pos;
   logic signed [ANGLE_W-1:0]   multi_ext;
   logic signed [ANGLE_W-1:0]   rel_pos;
   logic signed [ANGLE_W-1:0]   rel_bias;
   logic signed [SPD_OUT_W-1:0] speed_ext;

   // Handshakes
   assign b_load       = a_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !a_valid_ff || b_load;
   assign a_load       = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         zero_offset_ff <= ZERO_OFFSET_RESET;
         torque_k_ff    <= TORQUE_K_RESET;
         speed_mode_ff  <= 1'b0;
      end else if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_ZERO_OFFSET: zero_offset_ff <= csr_ch.data[POS_W-1:0];
            CSR_TORQUE_K:    torque_k_ff    <= csr_ch.data[TORQUE_K_W-1:0];
            CSR_SPEED_MODE:  speed_mode_ff  <= csr_ch.data[0];
            default: ;
         endcase
      end
   end

   // Capture the frame on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_load) begin
         a_valid_ff <= 1'b1;
      end else if (b_load) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_pos_ff     <= req_ch.position_raw;
         a_speed_ff   <= req_ch.speed_raw;
         a_current_ff <= req_ch.current_raw;
         a_temp_ff    <= req_ch.temp_raw;
      end
   end

   // Unwrap, angle and bias update
   always_comb begin
      // advance the frame counter, saturating one past calibration
      if (frame_count_ff < FC_W'(CAL_FRAMES + 1)) begin
         frame_count_in = frame_count_ff + FC_W'(1);
      end else begin
         frame_count_in = frame_count_ff;
      end

      // load the bias from the register over the first frames
      if (frame_count_in <= FC_W'(LOAD_FRAMES)) begin
         bias_cur = $signed({2'b00, zero_offset_ff});
      end else begin
         bias_cur = zero_bias_ff;
      end

      // wrap detection on the count step
      diff        = $signed({1'b0, a_pos_ff}) - $signed({1'b0, prev_pos_ff});
      prev_pos_in = a_pos_ff;
      priority if (diff < HALF_NEG) begin
         turns_in = turns_ff + TURN_BITS'(1);
         delta_in = diff + FULL_TURN;
      end else if (diff > HALF_POS) begin
         turns_in = turns_ff - TURN_BITS'(1);
         delta_in = diff - FULL_TURN;
      end else begin
         turns_in = turns_ff;
         delta_in = diff;
      end

      // position = count + turns * 65536, sign-extended
      multi_pos = $signed({turns_in, a_pos_ff});
      multi_ext = ANGLE_W'(multi_pos);
      multi_in  = multi_ext[MULTI_W-1:0];
      turn_in   = multi_ext[POS_W +: TURN_OUT_W];

      // angle = (position - bias) * 360, as 256 + 64 + 32 + 8
      rel_pos  = multi_ext - ANGLE_W'(bias_cur);
      angle_in = (rel_pos <<< 8) + (rel_pos <<< 6) + (rel_pos <<< 5) + (rel_pos <<< 3);

      // during calibration, set the bias one turn off the register offset, toward the position
      rel_bias     = ANGLE_W'(bias_cur) - multi_ext;
      zero_bias_in = bias_cur;
      if (frame_count_in <= FC_W'(CAL_FRAMES)) begin
         priority if (rel_bias < WIN_NEG) begin
            zero_bias_in = $signed({2'b01, zero_offset_ff});
         end else if (rel_bias > WIN_POS) begin
            zero_bias_in = $signed({2'b11, zero_offset_ff});
         end
      end

      // speed scaling, times six as 4 + 2, or passed through unscaled in speed mode
      speed_ext = SPD_OUT_W'(a_speed_ff);
      if (speed_mode_ff) begin
         speed_in = speed_ext;
      end else begin
         speed_in = (speed_ext <<< 2) + (speed_ext <<< 1);
      end

      // torque = current * constant, the full product fits the result width
      torque_in = TORQUE_W'(a_current_ff) * TORQUE_W'($signed({1'b0, torque_k_ff}));
   end

   // Hold the tracking state between frames
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pos_ff    <= '0;
         turns_ff       <= '0;
         zero_bias_ff   <= '0;
         frame_count_ff <= '0;
      end else if (b_load) begin
         prev_pos_ff    <= prev_pos_in;
         turns_ff       <= turns_in;
         zero_bias_ff   <= zero_bias_in;
         frame_count_ff <= frame_count_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (b_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (b_load) begin
         multi_ff  <= multi_in;
         delta_ff  <= delta_in;
         turn_ff   <= turn_in;
         angle_ff  <= angle_in;
         speed_ff  <= speed_in;
         torque_ff <= torque_in;
         temp_ff   <= a_temp_ff;
      end
   end

   assign rsp_ch.valid               = rsp_valid_ff;
   assign rsp_ch.multi_turn_position = multi_ff;
   assign rsp_ch.step_delta          = delta_ff;
   assign rsp_ch.turn_count          = turn_ff;
   assign rsp_ch.angle_deg_q16       = angle_ff;
   assign rsp_ch.speed_sixth_dps     = speed_ff;
   assign rsp_ch.torque_q24          = torque_ff;
   assign rsp_ch.temperature         = temp_ff;

endmodule

// ===== sv/mtmfd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtmfd_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
module mtmfd_checker
   import mtmfd_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [MULTI_W-1:0]    rsp_multi,
   input logic signed [DELTA_W-1:0]    rsp_delta,
   input logic signed [TURN_OUT_W-1:0] rsp_turns
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_multi) && $stable(rsp_delta))
      else $error("stalled result changed");

   // Nothing pending straight after reset
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // Turn count is the upper part of the multi-turn position
   a_turn_field: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_turns == rsp_multi[MULTI_W-1:POS_W])
      else $error("turn count disagrees with position");

   // Wrap correction keeps the step within half a turn
   a_delta_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_delta >= -17'sd32768) && (rsp_delta <= 17'sd32768))
      else $error("step delta beyond half a turn");

endmodule

bind multi_turn_motor_feedback_decoder_core mtmfd_checker u_mtmfd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_multi (rsp_ch.multi_turn_position),
   .rsp_delta (rsp_ch.step_delta),
   .rsp_turns (rsp_ch.turn_count)
);
